FILE: rtl/assert_macros.svh
// Assertion helpers shared by the monitor RTL. Every check is sampled on aclk
// and is switched off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Generic property check.
`define MAM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) \
        else $error(msg);

// Check that cond in one cycle implies expr in the next.
`define MAM_ASSERT_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error(msg);

`endif

FILE: rtl/mam_pkg.sv
package mam_pkg;

    localparam int AVG_LOG2_DEFAULT = 4;

    localparam int SAMPLE_W   = 16;
    localparam int ADC_W      = 10;
    localparam int OFFSET_W   = 11;
    localparam int CMD_W      = 2;
    localparam int NUM_CHAN   = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Channel codes carried on the cmd field.
    localparam logic [CMD_W-1:0] CH_SENSOR  = 2'd0;
    localparam logic [CMD_W-1:0] CH_CURRENT = 2'd1;
    localparam logic [CMD_W-1:0] CH_BOARD   = 2'd2;
    localparam logic [CMD_W-1:0] CH_UNUSED  = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_PROBE_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NO_SENSOR_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OVERTEMP_LIM  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_ZERO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_DRIVE_ENABLE  = 3'd4;

    localparam logic [SAMPLE_W-1:0] SENSOR_ALL_ONES = 16'hFFFF;
    localparam logic [ADC_W-1:0]    OVERTEMP_RESET  = 10'd1023;

endpackage

FILE: rtl/mam_ring_ram.sv
module mam_ring_ram #(
    parameter int ADDR_W = 6,
    parameter int DATA_W = 16
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read data only changes on a read, so a stalled consumer keeps its word.
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/mam_ptr.sv
`include "assert_macros.svh"

module mam_ptr #(
    parameter int AVG_LOG2 = mam_pkg::AVG_LOG2_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               advance,
    input  logic [mam_pkg::CMD_W-1:0]          cmd,
    output logic [AVG_LOG2+mam_pkg::CMD_W-1:0] rd_addr,
    output logic                               old_valid
);

    logic [AVG_LOG2-1:0]          pos_reg  [mam_pkg::NUM_CHAN];
    logic [AVG_LOG2-1:0]          pos_next [mam_pkg::NUM_CHAN];
    logic [mam_pkg::NUM_CHAN-1:0] wrap_reg;
    logic [mam_pkg::NUM_CHAN-1:0] wrap_next;
    logic [mam_pkg::CMD_W-1:0]    chan;

    // The unused code never advances a pointer; steer its lookup somewhere legal.
    assign chan = (cmd == mam_pkg::CH_UNUSED) ? mam_pkg::CH_SENSOR : cmd;

    // Slots are filled in order from zero, so the oldest slot holds real data
    // only once its ring has wrapped at least once. Before that it reads as zero.
    assign rd_addr   = {cmd, pos_reg[chan]};
    assign old_valid = wrap_reg[chan];

    always_comb begin
        for (int i = 0; i < mam_pkg::NUM_CHAN; i++) begin
            pos_next[i]  = pos_reg[i];
            wrap_next[i] = wrap_reg[i];
            if (advance && cmd == mam_pkg::CMD_W'(i)) begin
                pos_next[i]  = pos_reg[i] + AVG_LOG2'(1);
                wrap_next[i] = wrap_reg[i] | (&pos_reg[i]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mam_pkg::NUM_CHAN; i++) begin
                pos_reg[i] <= '0;
            end
            wrap_reg <= '0;
        end else begin
            for (int i = 0; i < mam_pkg::NUM_CHAN; i++) begin
                pos_reg[i] <= pos_next[i];
            end
            wrap_reg <= wrap_next;
        end
    end

    `MAM_ASSERT_NEXT(a_sensor_pos_step, advance && cmd == mam_pkg::CH_SENSOR,
        pos_reg[mam_pkg::CH_SENSOR] == $past(pos_reg[mam_pkg::CH_SENSOR]) + AVG_LOG2'(1),
        "sensor pointer did not step by one")
    `MAM_ASSERT_NEXT(a_sensor_wrap_set,
        advance && cmd == mam_pkg::CH_SENSOR && (&pos_reg[mam_pkg::CH_SENSOR]),
        wrap_reg[mam_pkg::CH_SENSOR], "sensor ring wrapped without marking its slots filled")

endmodule

FILE: rtl/three_channel_moving_average_monitor.sv
// Moving-average monitor for three converter channels (sensor voltage, TEC
// current, board temperature). Each sample transfer yields exactly one result
// transfer: the oldest ring entry is read from a single synchronous RAM in
// the cycle the sample is taken, and once the result register can take it the
// running sum is updated, the new sample is written back and the result
// register is loaded. Back-to-back samples of the same channel touch
// different ring slots, so no forwarding is needed and the rate stays at
// one sample per cycle as long as results are taken. No clearing
// pass runs after reset: a per-channel fill flag makes untouched slots read as
// zero, so the block is ready on the first cycle out of reset. Configuration
// writes are expected only while no sample is in flight; writing drive_enable
// clears the trip latch, which re-arms on the next sample if an error remains.
`include "assert_macros.svh"

module three_channel_moving_average_monitor #(
    parameter int AVG_LOG2 = mam_pkg::AVG_LOG2_DEFAULT
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,

    input  logic                                  cfg_we,
    input  logic [mam_pkg::CFG_IDX_W-1:0]         cfg_idx,
    input  logic [mam_pkg::CFG_DATA_W-1:0]        cfg_wdata,

    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [mam_pkg::CMD_W-1:0]             s_cmd,
    input  logic [mam_pkg::SAMPLE_W-1:0]          s_sample,

    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [mam_pkg::SAMPLE_W-1:0]          m_sensor_average,
    output logic [mam_pkg::SAMPLE_W-1:0]          m_latest_sensor,
    output logic signed [mam_pkg::OFFSET_W-1:0]   m_current_offset,
    output logic [mam_pkg::ADC_W-1:0]             m_board_average,
    output logic                                  m_sensor_error,
    output logic                                  m_overtemp_error,
    output logic                                  m_drive_enabled
);

    localparam int ADDR_W = AVG_LOG2 + mam_pkg::CMD_W;
    localparam int SSUM_W = mam_pkg::SAMPLE_W + AVG_LOG2;
    localparam int CSUM_W = mam_pkg::ADC_W + AVG_LOG2;
    localparam int SW     = mam_pkg::SAMPLE_W;
    localparam int AW     = mam_pkg::ADC_W;

    // Configuration.
    logic          probe_mode_reg;
    logic [SW-1:0] no_sensor_thr_reg;
    logic [AW-1:0] overtemp_lim_reg;
    logic [AW-1:0] current_zero_reg;
    logic          drive_enable_reg;
    logic          trip_clear;

    // Front end and update stage.
    logic                      s_accept;
    logic                      advance;
    logic [ADDR_W-1:0]         rd_addr;
    logic                      old_valid;
    logic [SW-1:0]             rd_data;
    logic                      v1_reg;
    logic                      v1_next;
    logic [mam_pkg::CMD_W-1:0] cmd1_reg;
    logic [SW-1:0]             sample1_reg;
    logic [ADDR_W-1:0]         addr1_reg;
    logic                      oldv1_reg;
    logic                      fire1;
    logic                      ram_we;
    logic [SW-1:0]             ram_wdata;
    logic [SW-1:0]             old_val;

    // Running state.
    logic [SSUM_W-1:0] sensor_sum_reg, sensor_sum_next;
    logic [CSUM_W-1:0] current_sum_reg, current_sum_next;
    logic [CSUM_W-1:0] board_sum_reg, board_sum_next;
    logic [SW-1:0]     last_sensor_reg, last_sensor_next;
    logic              sens_err_reg, sens_err_next;
    logic              ot_reg, ot_next;
    logic              trip_reg, trip_next;
    logic              trip_fire;
    logic              missing;
    logic [AW-1:0]     cur_avg;
    logic [AW-1:0]     board_avg;

    // Result register.
    logic                              m_valid_reg, m_valid_next;
    logic [SW-1:0]                     m_sensor_average_reg;
    logic [SW-1:0]                     m_latest_sensor_reg;
    logic [mam_pkg::OFFSET_W-1:0]      m_current_offset_reg;
    logic [AW-1:0]                     m_board_average_reg;
    logic                              m_sensor_error_reg;
    logic                              m_overtemp_error_reg;
    logic                              m_drive_enabled_reg;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign trip_clear = cfg_we && (cfg_idx == mam_pkg::REG_DRIVE_ENABLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_mode_reg    <= 1'b0;
            no_sensor_thr_reg <= '0;
            overtemp_lim_reg  <= mam_pkg::OVERTEMP_RESET;
            current_zero_reg  <= '0;
            drive_enable_reg  <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                mam_pkg::REG_PROBE_MODE:    probe_mode_reg    <= cfg_wdata[0];
                mam_pkg::REG_NO_SENSOR_THR: no_sensor_thr_reg <= cfg_wdata[SW-1:0];
                mam_pkg::REG_OVERTEMP_LIM:  overtemp_lim_reg  <= cfg_wdata[AW-1:0];
                mam_pkg::REG_CURRENT_ZERO:  current_zero_reg  <= cfg_wdata[AW-1:0];
                mam_pkg::REG_DRIVE_ENABLE:  drive_enable_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake and ring access
    // ------------------------------------------------------------------
    assign fire1    = v1_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !v1_reg || fire1;
    assign s_accept = s_valid && s_ready;
    assign advance  = s_accept && (s_cmd != mam_pkg::CH_UNUSED);

    mam_ptr #(
        .AVG_LOG2 (AVG_LOG2)
    ) u_ptr (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .cmd       (s_cmd),
        .rd_addr   (rd_addr),
        .old_valid (old_valid)
    );

    assign ram_we    = fire1 && (cmd1_reg != mam_pkg::CH_UNUSED);
    assign ram_wdata = (cmd1_reg == mam_pkg::CH_SENSOR) ? sample1_reg
                                                        : {{(SW-AW){1'b0}}, sample1_reg[AW-1:0]};

    mam_ring_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (SW)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (addr1_reg),
        .wdata (ram_wdata),
        .re    (advance),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    assign v1_next = s_accept ? 1'b1 : (fire1 ? 1'b0 : v1_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd1_reg    <= s_cmd;
            sample1_reg <= s_sample;
            addr1_reg   <= rd_addr;
            oldv1_reg   <= old_valid;
        end
    end

    // ------------------------------------------------------------------
    // Sum update and monitoring
    // ------------------------------------------------------------------
    assign old_val = oldv1_reg ? rd_data : '0;
    assign missing = probe_mode_reg ? (sample1_reg < no_sensor_thr_reg)
                                    : (sample1_reg == mam_pkg::SENSOR_ALL_ONES);

    always_comb begin
        sensor_sum_next  = sensor_sum_reg;
        current_sum_next = current_sum_reg;
        board_sum_next   = board_sum_reg;
        last_sensor_next = last_sensor_reg;
        sens_err_next    = sens_err_reg;
        if (fire1) begin
            case (cmd1_reg)
                mam_pkg::CH_SENSOR: begin
                    sensor_sum_next  = sensor_sum_reg - SSUM_W'(old_val)
                                       + SSUM_W'(sample1_reg);
                    last_sensor_next = sample1_reg;
                    sens_err_next    = missing;
                end
                mam_pkg::CH_CURRENT: begin
                    current_sum_next = current_sum_reg - CSUM_W'(old_val[AW-1:0])
                                       + CSUM_W'(sample1_reg[AW-1:0]);
                end
                mam_pkg::CH_BOARD: begin
                    board_sum_next = board_sum_reg - CSUM_W'(old_val[AW-1:0])
                                     + CSUM_W'(sample1_reg[AW-1:0]);
                end
                default: ;
            endcase
        end
    end

    assign cur_avg   = current_sum_next[CSUM_W-1:AVG_LOG2];
    assign board_avg = board_sum_next[CSUM_W-1:AVG_LOG2];

    // The overtemperature flag is sticky; only reset clears it.
    assign ot_next   = ot_reg | (fire1 && (board_avg > overtemp_lim_reg));
    assign trip_fire = trip_reg | sens_err_next | ot_next;

    always_comb begin
        if (trip_clear) begin
            trip_next = 1'b0;
        end else if (fire1) begin
            trip_next = trip_fire;
        end else begin
            trip_next = trip_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sensor_sum_reg  <= '0;
            current_sum_reg <= '0;
            board_sum_reg   <= '0;
            last_sensor_reg <= '0;
            sens_err_reg    <= 1'b0;
            ot_reg          <= 1'b0;
            trip_reg        <= 1'b0;
        end else begin
            sensor_sum_reg  <= sensor_sum_next;
            current_sum_reg <= current_sum_next;
            board_sum_reg   <= board_sum_next;
            last_sensor_reg <= last_sensor_next;
            sens_err_reg    <= sens_err_next;
            ot_reg          <= ot_next;
            trip_reg        <= trip_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    assign m_valid_next = fire1 ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire1) begin
            m_sensor_average_reg <= sensor_sum_next[SSUM_W-1:AVG_LOG2];
            m_latest_sensor_reg  <= last_sensor_next;
            m_current_offset_reg <= {1'b0, cur_avg} - {1'b0, current_zero_reg};
            m_board_average_reg  <= board_avg;
            m_sensor_error_reg   <= sens_err_next;
            m_overtemp_error_reg <= ot_next;
            m_drive_enabled_reg  <= drive_enable_reg && !trip_fire;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_sensor_average = m_sensor_average_reg;
    assign m_latest_sensor  = m_latest_sensor_reg;
    assign m_current_offset = signed'(m_current_offset_reg);
    assign m_board_average  = m_board_average_reg;
    assign m_sensor_error   = m_sensor_error_reg;
    assign m_overtemp_error = m_overtemp_error_reg;
    assign m_drive_enabled  = m_drive_enabled_reg;

    `MAM_ASSERT_NEXT(a_stage_hold, v1_reg && !fire1,
        v1_reg && $stable(addr1_reg), "pending sample lost while results stalled")
    `MAM_ASSERT_NEXT(a_overtemp_sticky, ot_reg, ot_reg,
        "overtemperature flag cleared outside reset")
    `MAM_ASSERT_NEXT(a_trip_on_error, fire1 && trip_fire && !trip_clear, trip_reg,
        "error seen but drive trip not latched")
    `MAM_ASSERT_NEXT(a_trip_cleared, trip_clear, !trip_reg,
        "drive enable write did not clear the trip latch")

endmodule

FILE: sim/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import mam_pkg::*;

    localparam int AVG_LOG2        = AVG_LOG2_DEFAULT;
    localparam int RING_LEN        = 1 << AVG_LOG2;
    localparam int SSUM_W          = SAMPLE_W + AVG_LOG2;
    localparam int CSUM_W          = ADC_W + AVG_LOG2;
    localparam int HALF_PERIOD     = 5;
    localparam int RESET_CYCLES    = 6;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 10;
    localparam int HOLD_CYCLES     = 60;
    localparam int QUIET_LIMIT     = 1000;
    localparam int NUM_PHASES      = 9;
    localparam int ITEMS_PER_PHASE = 55;

    typedef struct {
        logic [SAMPLE_W-1:0]        sensor_average;
        logic [SAMPLE_W-1:0]        latest_sensor;
        logic signed [OFFSET_W-1:0] current_offset;
        logic [ADC_W-1:0]           board_average;
        logic                       sensor_error;
        logic                       overtemp_error;
        logic                       drive_enabled;
    } monitor_result_t;

    class monitor_scoreboard;
        logic                         probe_mode;
        logic [SAMPLE_W-1:0]          no_sensor_threshold;
        logic [ADC_W-1:0]             overtemp_limit;
        logic [ADC_W-1:0]             current_zero;
        logic                         drive_enable;

        logic [SAMPLE_W-1:0]          sensor_ring [RING_LEN];
        logic [ADC_W-1:0]             current_ring [RING_LEN];
        logic [ADC_W-1:0]             board_ring [RING_LEN];
        logic [SAMPLE_W+AVG_LOG2-1:0] sensor_sum;
        logic [ADC_W+AVG_LOG2-1:0]    current_sum;
        logic [ADC_W+AVG_LOG2-1:0]    board_sum;
        logic [AVG_LOG2-1:0]          sensor_pos;
        logic [AVG_LOG2-1:0]          current_pos;
        logic [AVG_LOG2-1:0]          board_pos;
        logic [SAMPLE_W-1:0]          last_sensor;
        logic                         sensor_missing;
        logic                         overtemp_seen;
        logic                         trip_latched;

        monitor_result_t              expected_results [$];
        int                           failures;

        function new();
            probe_mode          = 1'b0;
            no_sensor_threshold = '0;
            overtemp_limit      = OVERTEMP_RESET;
            current_zero        = '0;
            drive_enable        = 1'b0;
            foreach (sensor_ring[i]) begin
                sensor_ring[i]  = '0;
                current_ring[i] = '0;
                board_ring[i]   = '0;
            end
            sensor_sum     = '0;
            current_sum    = '0;
            board_sum      = '0;
            sensor_pos     = '0;
            current_pos    = '0;
            board_pos      = '0;
            last_sensor    = '0;
            sensor_missing = 1'b0;
            overtemp_seen  = 1'b0;
            trip_latched   = 1'b0;
            failures       = 0;
        endfunction

        function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PROBE_MODE:    probe_mode = data[0];
                REG_NO_SENSOR_THR: no_sensor_threshold = data[SAMPLE_W-1:0];
                REG_OVERTEMP_LIM:  overtemp_limit = data[ADC_W-1:0];
                REG_CURRENT_ZERO:  current_zero = data[ADC_W-1:0];
                REG_DRIVE_ENABLE: begin
                    drive_enable = data[0];
                    trip_latched = 1'b0;
                end
                default: ;
            endcase
        endfunction

        // Computes the result that one accepted sample transfer produces.
        function void note_sample(logic [CMD_W-1:0] cmd, logic [SAMPLE_W-1:0] smp);
            monitor_result_t  r;
            logic [ADC_W-1:0] cur_avg;
            logic [ADC_W-1:0] brd_avg;

            case (cmd)
                CH_SENSOR: begin
                    sensor_sum = sensor_sum - SSUM_W'(sensor_ring[sensor_pos])
                                 + SSUM_W'(smp);
                    sensor_ring[sensor_pos] = smp;
                    sensor_pos++;
                    last_sensor = smp;
                    sensor_missing = probe_mode ? (smp < no_sensor_threshold)
                                                : (smp == SENSOR_ALL_ONES);
                end
                CH_CURRENT: begin
                    current_sum = current_sum - CSUM_W'(current_ring[current_pos])
                                  + CSUM_W'(smp[ADC_W-1:0]);
                    current_ring[current_pos] = smp[ADC_W-1:0];
                    current_pos++;
                end
                CH_BOARD: begin
                    board_sum = board_sum - CSUM_W'(board_ring[board_pos])
                                + CSUM_W'(smp[ADC_W-1:0]);
                    board_ring[board_pos] = smp[ADC_W-1:0];
                    board_pos++;
                end
                default: ;
            endcase

            brd_avg = board_sum[CSUM_W-1:AVG_LOG2];
            cur_avg = current_sum[CSUM_W-1:AVG_LOG2];
            if (brd_avg > overtemp_limit)
                overtemp_seen = 1'b1;
            if (sensor_missing || overtemp_seen)
                trip_latched = 1'b1;

            r.sensor_average = sensor_sum[SSUM_W-1:AVG_LOG2];
            r.latest_sensor  = last_sensor;
            r.current_offset = {1'b0, cur_avg} - {1'b0, current_zero};
            r.board_average  = brd_avg;
            r.sensor_error   = sensor_missing;
            r.overtemp_error = overtemp_seen;
            r.drive_enabled  = drive_enable && !trip_latched;
            expected_results.push_back(r);
        endfunction

        function void check_field(string name, logic [SAMPLE_W-1:0] want,
                                  logic [SAMPLE_W-1:0] got);
            if (got !== want) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                failures++;
            end
        endfunction

        function void check_result(monitor_result_t got);
            monitor_result_t want;

            if (expected_results.size() == 0) begin
                $error("result transfer with no sample outstanding");
                failures++;
                return;
            end
            want = expected_results.pop_front();
            check_field("sensor_average", want.sensor_average, got.sensor_average);
            check_field("latest_sensor", want.latest_sensor, got.latest_sensor);
            check_field("current_offset", want.current_offset, got.current_offset);
            check_field("board_average", want.board_average, got.board_average);
            check_field("sensor_error", want.sensor_error, got.sensor_error);
            check_field("overtemp_error", want.overtemp_error, got.overtemp_error);
            check_field("drive_enabled", want.drive_enabled, got.drive_enabled);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        cfg_we;
    logic [CFG_IDX_W-1:0]        cfg_idx;
    logic [CFG_DATA_W-1:0]       cfg_wdata;
    logic                        s_valid;
    logic                        s_ready;
    logic [CMD_W-1:0]            s_cmd;
    logic [SAMPLE_W-1:0]         s_sample;
    logic                        m_valid;
    logic                        m_ready;
    logic [SAMPLE_W-1:0]         m_sensor_average;
    logic [SAMPLE_W-1:0]         m_latest_sensor;
    logic signed [OFFSET_W-1:0]  m_current_offset;
    logic [ADC_W-1:0]            m_board_average;
    logic                        m_sensor_error;
    logic                        m_overtemp_error;
    logic                        m_drive_enabled;

    monitor_scoreboard sb = new();
    bit                idle_on = 1'b1;
    bit                hold_req = 1'b0;
    int                quiet_cycles = 0;

    three_channel_moving_average_monitor #(
        .AVG_LOG2(AVG_LOG2)
    ) dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_idx          (cfg_idx),
        .cfg_wdata        (cfg_wdata),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_cmd            (s_cmd),
        .s_sample         (s_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_sensor_average (m_sensor_average),
        .m_latest_sensor  (m_latest_sensor),
        .m_current_offset (m_current_offset),
        .m_board_average  (m_board_average),
        .m_sensor_error   (m_sensor_error),
        .m_overtemp_error (m_overtemp_error),
        .m_drive_enabled  (m_drive_enabled)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Result checking and the watchdog share the rising edge.
    always @(posedge aclk) begin
        monitor_result_t observed;

        if (aresetn && m_valid && m_ready) begin
            observed.sensor_average = m_sensor_average;
            observed.latest_sensor  = m_latest_sensor;
            observed.current_offset = m_current_offset;
            observed.board_average  = m_board_average;
            observed.sensor_error   = m_sensor_error;
            observed.overtemp_error = m_overtemp_error;
            observed.drive_enabled  = m_drive_enabled;
            sb.check_result(observed);
        end
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", sb.pending());
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Result side: random stall bursts, plus one long hold-off on request.
    initial begin
        int stall_left;

        stall_left = 0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                stall_left = $urandom_range(0, 4);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_sample(input logic [CMD_W-1:0] cmd, input logic [SAMPLE_W-1:0] smp);
        s_valid  <= 1'b1;
        s_cmd    <= cmd;
        s_sample <= smp;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_sample(cmd, smp);
        @(negedge aclk);
    endtask

    task automatic pause_sender(input int cycles);
        s_valid <= 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    // Stop offering samples and let every outstanding result drain.
    task automatic settle();
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic program_register(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        sb.apply_register(idx, data);
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Writes to unmapped indexes must leave every register untouched.
    task automatic poke_unmapped();
        for (int i = REG_DRIVE_ENABLE + 1; i < (1 << CFG_IDX_W); i++)
            program_register(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        logic [SAMPLE_W-1:0] v;

        case ($urandom_range(0, 9))
            0:       v = '0;
            1:       v = SENSOR_ALL_ONES;
            2:       v = SAMPLE_W'(sb.no_sensor_threshold + $urandom_range(0, 2) - 1);
            3:       v = $urandom_range(0, 1) ? 16'h03FF : 16'hFC00;
            default: v = SAMPLE_W'($urandom);
        endcase
        return v;
    endfunction

    task automatic send_random_sample();
        logic [CMD_W-1:0] cmd;

        if ($urandom_range(0, 15) == 0)
            cmd = CH_UNUSED;
        else
            cmd = CMD_W'($urandom_range(CH_SENSOR, CH_BOARD));
        send_sample(cmd, pick_sample());
    endtask

    initial begin
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = '0;
        cfg_wdata = '0;
        s_valid   = 1'b0;
        s_cmd     = CH_SENSOR;
        s_sample  = '0;
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Reset settings: thermistor sensor, drive off.
        send_sample(CH_SENSOR, 16'h0000);
        send_sample(CH_SENSOR, SENSOR_ALL_ONES);
        send_sample(CH_CURRENT, 16'h03FF);
        send_sample(CH_CURRENT, 16'hFC00);
        send_sample(CH_BOARD, 16'hFFFF);
        send_sample(CH_BOARD, 16'h0000);
        send_sample(CH_UNUSED, 16'hFFFF);
        send_sample(CH_SENSOR, 16'hFFFE);

        settle();
        program_register(REG_PROBE_MODE, 16'hFFFF);
        program_register(REG_NO_SENSOR_THR, 16'hFFFF);
        program_register(REG_CURRENT_ZERO, 16'hFFFF);
        program_register(REG_OVERTEMP_LIM, 16'hFFFF);
        program_register(REG_DRIVE_ENABLE, 16'h0001);
        poke_unmapped();

        // Current-output sensor: anything below the threshold reads as missing.
        send_sample(CH_SENSOR, 16'hFFFE);
        send_sample(CH_SENSOR, SENSOR_ALL_ONES);
        send_sample(CH_CURRENT, 16'h03FF);
        send_sample(CH_CURRENT, 16'h0000);
        send_sample(CH_BOARD, 16'h03FF);

        // The trip stays latched until drive_enable is written again.
        settle();
        program_register(REG_DRIVE_ENABLE, 16'hFFFF);
        program_register(REG_NO_SENSOR_THR, 16'h0000);
        program_register(REG_CURRENT_ZERO, 16'h0000);
        send_sample(CH_SENSOR, 16'h0000);
        send_sample(CH_CURRENT, 16'h03FF);
        send_sample(CH_UNUSED, 16'h0000);
        send_sample(CH_SENSOR, SENSOR_ALL_ONES);

        for (int p = 0; p < NUM_PHASES; p++) begin
            logic [CFG_DATA_W-1:0] thr;
            logic [CFG_DATA_W-1:0] zero;
            logic [CFG_DATA_W-1:0] limit;

            settle();
            case (p % 3)
                0:       thr = '0;
                1:       thr = 16'hFFFF;
                default: thr = CFG_DATA_W'($urandom);
            endcase
            zero = (p == 1) ? 16'h0000 : (p == 2) ? 16'hFFFF : 16'($urandom);
            // Overtemperature is sticky until reset, so it is armed only at the end.
            if (p == NUM_PHASES - 1)
                limit = 16'h0000;
            else if (p == NUM_PHASES - 2)
                limit = CFG_DATA_W'($urandom_range(400, 700));
            else
                limit = {CFG_DATA_W{1'b1}};
            program_register(REG_PROBE_MODE, CFG_DATA_W'($urandom));
            program_register(REG_NO_SENSOR_THR, thr);
            program_register(REG_CURRENT_ZERO, zero);
            program_register(REG_OVERTEMP_LIM, limit);
            program_register(REG_DRIVE_ENABLE,
                             (p == 3) ? 16'h0000 : (16'($urandom) | 16'h0001));
            if (p == 5)
                poke_unmapped();

            idle_on = (p != 4) && (p != NUM_PHASES - 1);
            if (p == 2)
                hold_req = 1'b1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                if (idle_on && $urandom_range(0, 3) == 0)
                    pause_sender($urandom_range(1, 5));
                send_random_sample();
            end
        end

        settle();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (sb.failures == 0 && sb.pending() == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/mam_pkg.sv
rtl/mam_ring_ram.sv
rtl/mam_ptr.sv
rtl/three_channel_moving_average_monitor.sv
sim/tb_top.sv
